/* rtl/core/cpba_pkg.sv */
// Package with types, constants and codes for the carrier pool bit allocator.
`default_nettype none
package cpba_pkg;
    localparam int CARRIER_SLOTS = 16;
    localparam int BLOCK_BYTES   = 4096;
    localparam int MAX_OUT       = 16;
    localparam int IDX_W         = (CARRIER_SLOTS > 1) ? $clog2(CARRIER_SLOTS) : 1;
    localparam int CNT_W         = $clog2(CARRIER_SLOTS + 1);
    localparam int NOUT_W        = $clog2(MAX_OUT + 1);
    localparam int TOT_W         = 37;
    localparam int BLK_BITS      = BLOCK_BYTES * 8;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;

    localparam logic [2:0] ST_SEGMENT  = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_INSUFF   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_UNMAPPED = 3'd4;
    localparam logic [2:0] ST_PARTIAL  = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] carrier_capacity;
        logic [31:0] request_bytes;
        logic [23:0] block_number;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  carrier_index;
        logic [31:0] offset_in_carrier;
        logic [31:0] segment_length;
        logic        last;
    } out_item_t;

    // Write port and read address from the sequencer to the carrier RAM.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [31:0]      wcap;
        logic [31:0]      wused;
        logic [IDX_W-1:0] raddr;
    } ram_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/cpba_ram.sv */
// Carrier table RAM: capacity and used count per slot, registered read.
`default_nettype none
module cpba_ram (
    input  wire logic               clk,
    input  wire cpba_pkg::ram_ctl_t ctl,
    output logic [31:0]             rcap,
    output logic [31:0]             rused
);
    import cpba_pkg::*;
    logic [63:0] mem [CARRIER_SLOTS];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= {ctl.wcap, ctl.wused};
        end
        {rcap, rused} <= mem[ctl.raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/cpba_seq.sv */
// Sequencer: decodes commands, walks the carrier table and emits results.
`default_nettype none
module cpba_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cpba_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cpba_pkg::out_item_t      out_data,
    output cpba_pkg::ram_ctl_t       ctl,
    input  wire logic [31:0]         rcap,
    input  wire logic [31:0]         rused
);
    import cpba_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_WALK, S_EMIT, S_FIN} state_t;

    state_t            state_reg;
    logic [1:0]        op_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TOT_W-1:0]  cap_tot_reg, used_tot_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [35:0]       need_reg;   // bits still to place
    logic [36:0]       off_reg;    // map: bits still to skip (block base below 2^37; a larger base sets off_big_reg)
    logic              off_big_reg;
    logic              map_part_reg; // map: block end lies beyond all used bits
    logic [35:0]       done_reg;
    logic [NOUT_W-1:0] nout_reg;
    logic              pend_reg;   // one segment held back until the next is known
    out_item_t         pend_item_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    logic [31:0] avail;
    logic [35:0] take;
    logic [36:0] mlen;
    logic        walk_end;
    logic [TOT_W-1:0] freeb;
    logic [51:0] base;

    assign freeb = cap_tot_reg - used_tot_reg;
    assign base  = {28'd0, in_data.block_number} * 52'(BLK_BITS);
    assign avail = (rcap > rused) ? rcap - rused : 32'd0;
    assign take  = (need_reg < {4'd0, avail}) ? need_reg : {4'd0, avail};
    assign mlen  = (37'(need_reg) < ({5'd0, rused} - off_reg)) ? 37'(need_reg)
                                                               : ({5'd0, rused} - off_reg);
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        ctl       = '0;
        ctl.raddr = idx_reg;
        ctl.waddr = idx_reg;
        ctl.wcap  = rcap;
        ctl.wused = rused + take[31:0];
        if (state_reg == S_IDLE && in_valid && in_ready && in_data.opcode == OP_ADD
            && count_reg < CNT_W'(CARRIER_SLOTS))
        begin
            ctl.we    = 1'b1;
            ctl.waddr = count_reg[IDX_W-1:0];
            ctl.wcap  = in_data.carrier_capacity;
            ctl.wused = '0;
        end
        else if (state_reg == S_WALK && op_reg == OP_ALLOC && avail != 0
                 && (!pend_reg || out_ready || !out_valid_reg))
        begin
            ctl.we = 1'b1;
        end
    end

    function automatic out_item_t mk(input logic [2:0] st, input logic [3:0] ix,
                                     input logic [31:0] of, input logic [31:0] ln,
                                     input logic la);
        out_item_t r;
        r.status = st; r.carrier_index = ix; r.offset_in_carrier = of;
        r.segment_length = ln; r.last = la;
        return r;
    endfunction

    // Next walk step exists when another slot remains and output room remains.
    always_comb
    begin
        walk_end = (32'(idx_reg) + 1 >= 32'(count_reg)) || (nout_reg >= NOUT_W'(MAX_OUT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        out_item_t out_next;
        logic      out_valid_next;
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_tot_reg   <= '0;
            used_tot_reg  <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            out_next       = out_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg   <= in_data.opcode;
                        idx_reg  <= '0;
                        nout_reg <= '0;
                        done_reg <= '0;
                        pend_reg <= 1'b0;
                        case (in_data.opcode)
                            OP_ADD:
                            begin
                                out_valid_next = 1'b1;
                                if (count_reg < CNT_W'(CARRIER_SLOTS))
                                begin
                                    out_next = mk(ST_DONE, 4'(count_reg), '0, '0, 1'b1);
                                    count_reg <= count_reg + 1'b1;
                                    cap_tot_reg <= cap_tot_reg + TOT_W'(in_data.carrier_capacity);
                                end
                                else
                                begin
                                    out_next = mk(ST_FULL, '0, '0, '0, 1'b1);
                                end
                            end
                            OP_ALLOC:
                            begin
                                need_reg <= {in_data.request_bytes, 3'b000, 1'b0} >> 1;
                                if (freeb < {2'b00, in_data.request_bytes, 3'b000})
                                begin
                                    out_next = mk(ST_INSUFF, '0, '0, '0, 1'b1);
                                    out_valid_next = 1'b1;
                                end
                                else if (in_data.request_bytes == 0 || count_reg == 0)
                                begin
                                    out_next = mk(ST_DONE, '0, '0, '0, 1'b1);
                                    out_valid_next = 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            OP_MAP:
                            begin
                                need_reg     <= 36'(BLK_BITS);
                                off_reg      <= base[36:0];
                                off_big_reg  <= |base[51:37];
                                // The used regions add up to the used total.
                                map_part_reg <= {15'd0, used_tot_reg} < base + 52'(BLK_BITS);
                                if (count_reg == 0)
                                begin
                                    out_next = mk(ST_UNMAPPED, '0, '0, '0, 1'b1);
                                    out_valid_next = 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            default:
                            begin
                                out_next = mk(ST_DONE, '0, '0, '0, 1'b1);
                                out_valid_next = 1'b1;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    // A new segment needs the held one delivered first.
                    if (!(out_valid_reg && !out_ready))
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            if (avail != 0)
                            begin
                                if (pend_reg)
                                begin
                                    out_next = pend_item_reg;
                                    out_valid_next = 1'b1;
                                end
                                pend_reg <= 1'b1;
                                pend_item_reg <= mk(ST_SEGMENT, 4'(idx_reg), rused,
                                                    take[31:0], 1'b0);
                                nout_reg <= nout_reg + 1'b1;
                                need_reg <= need_reg - take;
                                done_reg <= done_reg + take;
                            end
                            if (walk_end || (avail != 0 && take == need_reg)
                                || (avail != 0 && nout_reg + 1'b1 >= NOUT_W'(MAX_OUT)))
                            begin
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                state_reg <= S_READ;
                            end
                        end
                        else
                        begin
                            if (off_big_reg || off_reg >= {5'd0, rused})
                            begin
                                if (!off_big_reg)
                                begin
                                    off_reg <= off_reg - {5'd0, rused};
                                end
                                if (walk_end)
                                begin
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 1'b1;
                                    state_reg <= S_READ;
                                end
                            end
                            else
                            begin
                                if (pend_reg)
                                begin
                                    out_next = pend_item_reg;
                                    out_valid_next = 1'b1;
                                end
                                pend_reg <= 1'b1;
                                pend_item_reg <= mk(map_part_reg ? ST_PARTIAL : ST_SEGMENT,
                                                    4'(idx_reg), off_reg[31:0],
                                                    mlen[31:0], 1'b0);
                                nout_reg <= nout_reg + 1'b1;
                                need_reg <= need_reg - 36'(mlen);
                                off_reg  <= '0;
                                if (walk_end || mlen == 37'(need_reg)
                                    || nout_reg + 1'b1 >= NOUT_W'(MAX_OUT))
                                begin
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 1'b1;
                                    state_reg <= S_READ;
                                end
                            end
                        end
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_EMIT;
                    if (op_reg == OP_ALLOC)
                    begin
                        used_tot_reg <= used_tot_reg + TOT_W'(done_reg);
                    end
                end
                S_EMIT:
                begin
                    if (!(out_valid_reg && !out_ready))
                    begin
                        out_valid_next = 1'b1;
                        state_reg <= S_IDLE;
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            out_next = mk((op_reg == OP_MAP) ? ST_UNMAPPED : ST_DONE,
                                          '0, '0, '0, 1'b1);
                        end
                        else
                        begin
                            out_next = pend_item_reg;
                            out_next.last = 1'b1;
                            if (op_reg == OP_MAP && need_reg != 0)
                            begin
                                out_next.status = ST_PARTIAL;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/carrier_pool_bit_allocator_unit.sv */
// Top level of the carrier pool bit allocator.
//
// One input channel carries commands (add carrier, allocate, map block), one
// output channel carries result items; both use valid/ready transfers.
// Add carrier, no-room, zero-byte and empty-table cases skip the walk. Allocate and
// map walk the carrier RAM one slot at a time, each slot in a read state
// (registered read) and then a walk state (update), followed by a finish
// state and an emit state.
// The block takes one command at a time; a new command is accepted once the
// previous one has been fully transferred out.
// Whether a map block is only partly covered follows from the used total at
// acceptance. The last flag is known only at the end of the walk, so each
// segment is held one step and transferred when the next one (or the end) is known.
// When the receiver stalls, the walk pauses with its state intact.
// Reset clears the carrier count and the pool totals; the RAM needs no
// clearing since only slots below the count are ever read.
`default_nettype none
module carrier_pool_bit_allocator_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cpba_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cpba_pkg::out_item_t      out_data
);
    import cpba_pkg::*;
    ram_ctl_t    ctl;
    logic [31:0] rcap, rused;

    cpba_ram u_ram (.clk(clk), .ctl(ctl), .rcap(rcap), .rused(rused));

    cpba_seq u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .ctl(ctl), .rcap(rcap), .rused(rused)
    );
endmodule
`default_nettype wire

/* rtl/core/cpba_checker.sv */
// Port-level checker for the carrier pool bit allocator, bound to the top level.
`default_nettype none
module cpba_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire cpba_pkg::out_item_t out_data
);
    import cpba_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("command withdrawn before its transfer");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_PARTIAL)
        else $error("bad status code");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_SEGMENT && out_data.status != ST_PARTIAL
        |-> out_data.last)
        else $error("status result without last");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("command accepted while a result is pending");
endmodule

bind carrier_pool_bit_allocator_unit cpba_checker u_cpba_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
